/* rtl/ots_pkg.sv */
package ots_pkg;

	localparam int OWNER_W = 8;
	localparam int COUNT_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam int DEF_HOLDER_SLOTS = 16;
	localparam int DEF_WAITER_SLOTS = 16;
	localparam int DEF_OWNER_BITS = 8;

	typedef enum logic [1:0] {
		OP_RELEASE = 2'd0,
		OP_ACQUIRE = 2'd1,
		OP_TRY     = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_RELEASED  = 3'd0,
		STAT_IGNORED   = 3'd1,
		STAT_ACQUIRED  = 3'd2,
		STAT_REFUSED   = 3'd3,
		STAT_QUEUED    = 3'd4,
		STAT_GRANTED   = 3'd5,
		STAT_FULL      = 3'd6,
		STAT_COUNT     = 3'd7
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_COUNT = 2'd0,
		CFG_MIN_COUNT   = 2'd1,
		CFG_MAX_COUNT   = 2'd2
	} cfg_reg_t;

endpackage

/* rtl/ots_req_if.sv */
interface ots_req_if;
	logic                         valid;
	logic                         ready;
	ots_pkg::op_t                 op;
	logic [ots_pkg::OWNER_W-1:0]  owner;

	modport source (output valid, output op, output owner, input ready);
	modport sink   (input valid, input op, input owner, output ready);
endinterface

/* rtl/ots_rsp_if.sv */
interface ots_rsp_if;
	logic                                valid;
	logic                                ready;
	ots_pkg::status_t                    status;
	logic [ots_pkg::OWNER_W-1:0]         who;
	logic signed [ots_pkg::COUNT_W-1:0]  count;
	logic                                last;

	modport source (output valid, output status, output who, output count, output last,
		input ready);
	modport sink   (input valid, input status, input who, input count, input last,
		output ready);
endinterface

/* rtl/owner_tracked_counting_semaphore.sv */
// Channel   Dir  Payload                          Transfer
// req       in   op, owner                        valid & ready at rising clk
// rsp       out  status, who, count, last         valid & ready at rising clk
// cfg       in   cfg_index, cfg_data              cfg_write_en at rising clk
//
// Reads, refused tries and queued or queue-full acquires go straight to a result.
// Release, and acquire or try above the floor, walk the holder table one entry per
// cycle through a single compare unit fed by the holder memory read port. A release
// that frees a slot for a queued waiter then goes on to a grant step.
// Reset (arst_n low) empties holder table and waiter queue, loads count 0, floor 0,
// ceiling 1. No clearing pass is needed: holder entries carry valid flops.
// req is taken only between items; a result held in the output register does not
// block the next transfer on req, but a stalled rsp holds the sequencer at its
// next result.
module owner_tracked_counting_semaphore #(
	parameter int HOLDER_SLOTS = ots_pkg::DEF_HOLDER_SLOTS,
	parameter int WAITER_SLOTS = ots_pkg::DEF_WAITER_SLOTS,
	parameter int OWNER_BITS   = ots_pkg::DEF_OWNER_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ots_req_if.sink                            req,
	ots_rsp_if.source                          rsp,
	input  logic                               cfg_write_en,
	input  logic [ots_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ots_pkg::COUNT_W-1:0]        cfg_data
);

	localparam int HIDX_W = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
	localparam int WIDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int LVL_W  = $clog2(WAITER_SLOTS + 1);
	localparam logic [HIDX_W-1:0] HOLDER_LAST = HIDX_W'(HOLDER_SLOTS - 1);
	localparam logic [WIDX_W-1:0] WAITER_LAST = WIDX_W'(WAITER_SLOTS - 1);
	localparam logic [LVL_W-1:0]  WAITER_FULL = LVL_W'(WAITER_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_REL,
		S_EMIT,
		S_GRANT
	} state_t;

	typedef logic signed [ots_pkg::COUNT_W-1:0] count_t;

	state_t                     state_q;
	logic [ots_pkg::OWNER_W-1:0] owner_q;
	logic [OWNER_BITS-1:0]      id_q;

	count_t                     count_q;
	count_t                     min_q;
	count_t                     max_q;

	// Holder table: valid flops, owner ids in memory
	logic [HOLDER_SLOTS-1:0]    holder_vld_q;
	logic [OWNER_BITS-1:0]      holder_mem [HOLDER_SLOTS];

	// Waiter queue
	logic [OWNER_BITS-1:0]      waiter_mem [WAITER_SLOTS];
	logic [WIDX_W-1:0]          head_q;
	logic [WIDX_W-1:0]          tail_q;
	logic [LVL_W-1:0]           level_q;
	logic [OWNER_BITS-1:0]      waiter_rd_q;

	// Scan walker
	logic [HIDX_W-1:0]          idx_q;
	logic                       issued_q;
	logic                       look_free_q;
	logic                       scan_s1;
	logic [HIDX_W-1:0]          idx_s1;
	logic                       ent_vld_s1;
	logic [OWNER_BITS-1:0]      ent_own_s1;
	logic [HIDX_W-1:0]          slot_q;

	// Pending result and output register
	ots_pkg::status_t           res_status_q;
	logic [ots_pkg::OWNER_W-1:0] res_who_q;
	logic                       res_last_q;
	logic                       grant_q;

	logic                       out_valid_q;
	ots_pkg::status_t           out_status_q;
	logic [ots_pkg::OWNER_W-1:0] out_who_q;
	count_t                     out_count_q;
	logic                       out_last_q;

	logic                       accept;
	logic                       count_above;
	logic                       scan_issue;
	logic                       scan_hit;
	logic                       scan_miss;
	count_t                     rel_count;
	logic                       rel_grant;
	logic                       out_free;
	logic                       holder_we;
	logic [HIDX_W-1:0]          holder_wa;
	logic [OWNER_BITS-1:0]      holder_wd;
	logic                       waiter_we;

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign count_above = (count_q > min_q);
	assign out_free    = !out_valid_q || rsp.ready;

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.who    = out_who_q;
	assign rsp.count  = out_count_q;
	assign rsp.last   = out_last_q;

	// Shared compare: one holder entry per cycle, looking for a match or a hole
	assign scan_issue = (state_q == S_SCAN) && !issued_q;
	assign scan_hit   = (state_q == S_SCAN) && scan_s1 &&
		(look_free_q ? !ent_vld_s1 : (ent_vld_s1 && (ent_own_s1 == id_q)));
	assign scan_miss  = (state_q == S_SCAN) && scan_s1 && !scan_hit &&
		(idx_s1 == HOLDER_LAST);

	// Release raises the count by one unless at or above the ceiling, then clamps
	assign rel_count = (count_q < max_q) ? count_t'(count_q + count_t'(1)) : max_q;
	assign rel_grant = (level_q != '0) && (rel_count > min_q);

	assign waiter_we = accept && (req.op == ots_pkg::OP_ACQUIRE) && !count_above &&
		(level_q != WAITER_FULL);

	always_comb begin
		holder_we = 1'b0;
		holder_wa = slot_q;
		holder_wd = waiter_rd_q;
		if (scan_hit && look_free_q) begin
			holder_we = 1'b1;
			holder_wa = idx_s1;
			holder_wd = id_q;
		end else if (state_q == S_GRANT) begin
			holder_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (holder_we) begin
			holder_mem[holder_wa] <= holder_wd;
		end
		if (scan_issue) begin
			ent_own_s1 <= holder_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (waiter_we) begin
			waiter_mem[tail_q] <= OWNER_BITS'(req.owner);
		end
		if (state_q == S_REL) begin
			waiter_rd_q <= waiter_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			owner_q      <= '0;
			id_q         <= '0;
			count_q      <= '0;
			min_q        <= '0;
			max_q        <= count_t'(1);
			holder_vld_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			level_q      <= '0;
			idx_q        <= '0;
			issued_q     <= 1'b0;
			look_free_q  <= 1'b0;
			scan_s1      <= 1'b0;
			idx_s1       <= '0;
			ent_vld_s1   <= 1'b0;
			slot_q       <= '0;
			res_status_q <= ots_pkg::STAT_COUNT;
			res_who_q    <= '0;
			res_last_q   <= 1'b0;
			grant_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ots_pkg::STAT_COUNT;
			out_who_q    <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// Drop the output once taken, unless a new result loads this cycle
			if (rsp.ready && !((state_q == S_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end

			// Config must land only between items; the block itself does not enforce it
			if (cfg_write_en) begin
				case (cfg_index)
					ots_pkg::CFG_START_COUNT: count_q <= $signed(cfg_data);
					ots_pkg::CFG_MIN_COUNT:   min_q   <= $signed(cfg_data);
					ots_pkg::CFG_MAX_COUNT:   max_q   <= $signed(cfg_data);
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						owner_q    <= req.owner;
						id_q       <= OWNER_BITS'(req.owner);
						res_who_q  <= req.owner;
						res_last_q <= 1'b1;
						idx_q      <= '0;
						issued_q   <= 1'b0;
						scan_s1    <= 1'b0;
						grant_q    <= 1'b0;
						case (req.op)
							ots_pkg::OP_READ: begin
								res_status_q <= ots_pkg::STAT_COUNT;
								state_q      <= S_EMIT;
							end
							ots_pkg::OP_RELEASE: begin
								look_free_q <= 1'b0;
								state_q     <= S_SCAN;
							end
							default: begin
								if (count_above) begin
									look_free_q <= 1'b1;
									state_q     <= S_SCAN;
								end else if (req.op == ots_pkg::OP_TRY) begin
									res_status_q <= ots_pkg::STAT_REFUSED;
									state_q      <= S_EMIT;
								end else if (level_q == WAITER_FULL) begin
									res_status_q <= ots_pkg::STAT_FULL;
									state_q      <= S_EMIT;
								end else begin
									// Queue the owner at the tail
									tail_q       <= (tail_q == WAITER_LAST) ? '0 :
										WIDX_W'(tail_q + 1'b1);
									level_q      <= LVL_W'(level_q + 1'b1);
									res_status_q <= ots_pkg::STAT_QUEUED;
									state_q      <= S_EMIT;
								end
							end
						endcase
					end
				end

				S_SCAN: begin
					// Advance the compare stage; drop it once the walk ends
					scan_s1 <= scan_issue && !scan_hit;
					if (scan_issue) begin
						idx_s1     <= idx_q;
						ent_vld_s1 <= holder_vld_q[idx_q];
						if (idx_q == HOLDER_LAST) begin
							issued_q <= 1'b1;
						end else begin
							idx_q <= HIDX_W'(idx_q + 1'b1);
						end
					end

					if (scan_hit) begin
						slot_q  <= idx_s1;
						if (look_free_q) begin
							// Take the hole for the requester
							holder_vld_q[idx_s1] <= 1'b1;
							count_q              <= count_t'(count_q - count_t'(1));
							res_status_q         <= ots_pkg::STAT_ACQUIRED;
							state_q              <= S_EMIT;
						end else begin
							state_q <= S_REL;
						end
					end else if (scan_miss) begin
						res_status_q <= look_free_q ? ots_pkg::STAT_FULL :
							ots_pkg::STAT_IGNORED;
						state_q      <= S_EMIT;
					end
				end

				S_REL: begin
					// Drop the holder entry; waiter read is issued in this cycle
					holder_vld_q[slot_q] <= 1'b0;
					count_q              <= rel_count;
					grant_q              <= rel_grant;
					res_status_q         <= ots_pkg::STAT_RELEASED;
					res_who_q            <= owner_q;
					res_last_q           <= !rel_grant;
					state_q              <= S_EMIT;
				end

				S_GRANT: begin
					// Hand the freed slot to the head waiter
					holder_vld_q[slot_q] <= 1'b1;
					head_q               <= (head_q == WAITER_LAST) ? '0 :
						WIDX_W'(head_q + 1'b1);
					level_q              <= LVL_W'(level_q - 1'b1);
					count_q              <= count_t'(count_q - count_t'(1));
					grant_q              <= 1'b0;
					res_status_q         <= ots_pkg::STAT_GRANTED;
					res_who_q            <= ots_pkg::OWNER_W'(waiter_rd_q);
					res_last_q           <= 1'b1;
					state_q              <= S_EMIT;
				end

				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_who_q    <= res_who_q;
						out_count_q  <= count_q;
						out_last_q   <= res_last_q;
						state_q      <= grant_q ? S_GRANT : S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Waiter level never passes the queue depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= WAITER_FULL)
		else $error("waiter level above queue depth");

	// A grant only runs with a waiter queued and onto a freed slot
	a_grant_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRANT) |-> ((level_q != '0) && !holder_vld_q[slot_q]))
		else $error("grant without waiter or onto a held slot");

	// A non-final result is always the release ahead of a grant
	a_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> (rsp.status == ots_pkg::STAT_RELEASED))
		else $error("non-final result that is not a release");

	// Leaving idle goes only to the table walk or straight to a result
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (state_q == S_IDLE || state_q == S_SCAN ||
			state_q == S_EMIT))
		else $error("item left idle for an unexpected step");

endmodule

/* tb/owner_tracked_counting_semaphore_tb.sv */
// Tracks what the semaphore should answer: its own count, floor, ceiling,
// holder table and waiter queue, plus the results still owed by the block.
class semaphore_scoreboard;

	typedef struct {
		ots_pkg::status_t             status;
		logic [ots_pkg::OWNER_W-1:0]  who;
		logic signed [15:0]           count;
		logic                         last;
	} sem_result_t;

	localparam int N_HOLDERS = ots_pkg::DEF_HOLDER_SLOTS;
	localparam int N_WAITERS = ots_pkg::DEF_WAITER_SLOTS;
	localparam logic [7:0] ID_MASK = 8'((1 << ots_pkg::DEF_OWNER_BITS) - 1);

	logic signed [15:0] sem_count;
	logic signed [15:0] floor_count;
	logic signed [15:0] ceil_count;
	bit                 holder_used[N_HOLDERS];
	logic [7:0]         holder_id[N_HOLDERS];
	logic [7:0]         waiters[$];
	sem_result_t        owed_results[$];
	int                 errors;

	function new();
		sem_count = 16'sd0;
		floor_count = 16'sd0;
		ceil_count = 16'sd1;
		foreach (holder_used[i]) begin
			holder_used[i] = 1'b0;
			holder_id[i] = '0;
		end
		errors = 0;
	endfunction

	function int pending();
		return owed_results.size();
	endfunction

	function void owe(ots_pkg::status_t st, logic [7:0] who, logic last);
		sem_result_t r;
		r.status = st;
		r.who = who;
		r.count = sem_count;
		r.last = last;
		owed_results.insert(owed_results.size(), r);
	endfunction

	// Start count loads the count; floor and ceiling only take effect later.
	function void load_register(logic [1:0] idx, logic [15:0] val);
		case (idx)
			ots_pkg::CFG_START_COUNT: sem_count = val;
			ots_pkg::CFG_MIN_COUNT:   floor_count = val;
			ots_pkg::CFG_MAX_COUNT:   ceil_count = val;
			default: ;
		endcase
	endfunction

	function void note_request(ots_pkg::op_t op, logic [7:0] owner);
		int slot;
		logic [7:0] id;
		logic [7:0] woken;
		slot = -1;
		id = owner & ID_MASK;
		case (op)
			ots_pkg::OP_READ: owe(ots_pkg::STAT_COUNT, owner, 1'b1);
			ots_pkg::OP_RELEASE: begin
				for (int i = N_HOLDERS - 1; i >= 0; i--)
					if (holder_used[i] && holder_id[i] == id)
						slot = i;
				if (slot < 0) begin
					owe(ots_pkg::STAT_IGNORED, owner, 1'b1);
				end else begin
					holder_used[slot] = 1'b0;
					if (sem_count < ceil_count)
						sem_count = sem_count + 16'sd1;
					if (sem_count > ceil_count)
						sem_count = ceil_count;
					if (waiters.size() > 0 && sem_count > floor_count) begin
						owe(ots_pkg::STAT_RELEASED, owner, 1'b0);
						woken = waiters.pop_front();
						holder_used[slot] = 1'b1;
						holder_id[slot] = woken & ID_MASK;
						sem_count = sem_count - 16'sd1;
						owe(ots_pkg::STAT_GRANTED, woken, 1'b1);
					end else begin
						owe(ots_pkg::STAT_RELEASED, owner, 1'b1);
					end
				end
			end
			default: begin
				if (sem_count > floor_count) begin
					for (int i = N_HOLDERS - 1; i >= 0; i--)
						if (!holder_used[i])
							slot = i;
					if (slot < 0) begin
						owe(ots_pkg::STAT_FULL, owner, 1'b1);
					end else begin
						holder_used[slot] = 1'b1;
						holder_id[slot] = id;
						sem_count = sem_count - 16'sd1;
						owe(ots_pkg::STAT_ACQUIRED, owner, 1'b1);
					end
				end else if (op == ots_pkg::OP_TRY) begin
					owe(ots_pkg::STAT_REFUSED, owner, 1'b1);
				end else if (waiters.size() >= N_WAITERS) begin
					owe(ots_pkg::STAT_FULL, owner, 1'b1);
				end else begin
					waiters.insert(waiters.size(), id);
					owe(ots_pkg::STAT_QUEUED, owner, 1'b1);
				end
			end
		endcase
	endfunction

	task report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task check_result(ots_pkg::status_t st, logic [7:0] who, logic signed [15:0] cnt,
		logic last);
		sem_result_t want;
		if (owed_results.size() == 0) begin
			report($sformatf("unexpected result status %0d who %0h count %0d", st, who, cnt));
			return;
		end
		want = owed_results.pop_front();
		if (st !== want.status)
			report($sformatf("status %0d, expected %0d", st, want.status));
		if (who !== want.who)
			report($sformatf("who %0h, expected %0h", who, want.who));
		if (cnt !== want.count)
			report($sformatf("count %0d, expected %0d", cnt, want.count));
		if (last !== want.last)
			report($sformatf("last %0b, expected %0b", last, want.last));
	endtask

endclass

module owner_tracked_counting_semaphore_tb;

	// Index with no register behind it; the block must ignore writes to it.
	localparam logic [ots_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	// The slowest single item is a release that ends in a grant.
	localparam int SETTLE_CYCLES = 2 * ots_pkg::DEF_HOLDER_SLOTS + 8;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 85;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write_en;
	logic [ots_pkg::CFG_INDEX_W-1:0]  cfg_index;
	logic [ots_pkg::COUNT_W-1:0]      cfg_data;

	// Idling switches: drawn at random per phase, both off for the closing phase.
	bit sender_gaps;
	bit receiver_stalls;

	ots_req_if req_ch ();
	ots_rsp_if rsp_ch ();

	semaphore_scoreboard sb = new();

	owner_tracked_counting_semaphore dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("owner_tracked_counting_semaphore_tb NOT OK");
		$finish;
	end

	// Response side: hold ready low for random bursts while stalls are enabled.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check every response transfer against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result(rsp_ch.status, rsp_ch.who, rsp_ch.count, rsp_ch.last);
	end

	// Present one request and hold it until the transfer. Valid stays high
	// between back-to-back requests; a random gap drops it low first.
	task automatic send_request(ots_pkg::op_t op, logic [ots_pkg::OWNER_W-1:0] owner);
		int gap;
		gap = 0;
		if (sender_gaps && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.owner <= owner;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(op, owner);
	endtask

	// Drop valid, wait for every owed result, then let the block go quiet.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_register(logic [ots_pkg::CFG_INDEX_W-1:0] idx,
		logic [ots_pkg::COUNT_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		sb.load_register(idx, val);
	endtask

	// Write all three registers in a shuffled order, then optionally the unused index;
	// the enable stays high across the writes and drops once at the end.
	task automatic configure(logic [15:0] start_v, logic [15:0] min_v, logic [15:0] max_v,
		bit poke_unused);
		logic [15:0] vals[3];
		int order[3];
		int j;
		int t;
		logic [ots_pkg::CFG_INDEX_W-1:0] idx;
		vals[ots_pkg::CFG_START_COUNT] = start_v;
		vals[ots_pkg::CFG_MIN_COUNT]   = min_v;
		vals[ots_pkg::CFG_MAX_COUNT]   = max_v;
		order = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < 3; i++) begin
			idx = ots_pkg::CFG_INDEX_W'(order[i]);
			put_register(idx, vals[order[i]]);
		end
		if (poke_unused)
			put_register(CFG_UNUSED, 16'($urandom));
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [15:0] to_count(int v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// One random phase: pick a setting, then mostly requests from a small
	// pool of owners so that releases find holders and waiters get granted.
	task automatic random_phase(int n_items);
		logic [7:0] pool[6];
		int kind;
		int lo;
		int hi;
		int st;
		int rel_pct;
		int r;
		ots_pkg::op_t op;
		logic [7:0] owner;
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 3);
		case (kind)
			0: begin
				// widest window: acquires succeed while the count is above the floor and a slot is free
				lo = -32768;
				hi = 32767;
				r = $urandom_range(0, 2);
				st = (r == 0) ? 32767 : (r == 1) ? -32768 :
					int'($urandom_range(0, 65535)) - 32768;
			end
			1: begin
				// floor at the top: nothing is ever acquired, waiters pile up
				lo = 32767;
				hi = int'($urandom_range(0, 65535)) - 32768;
				st = int'($urandom_range(0, 65535)) - 32768;
			end
			2: begin
				lo = -32768;
				hi = -32768;
				st = -32768;
			end
			3: begin
				lo = int'($urandom_range(0, 65535)) - 32768;
				hi = int'($urandom_range(0, 65535)) - 32768;
				st = int'($urandom_range(0, 65535)) - 32768;
			end
			default: begin
				// narrow window near a random base; start may lie outside it
				lo = (r % 2 == 0) ? int'($urandom_range(0, 40)) - 20
					: int'($urandom_range(0, 65535)) - 32768;
				hi = lo + int'($urandom_range(0, 8));
				st = lo + int'($urandom_range(0, 12)) - 2;
			end
		endcase
		configure(to_count(st), to_count(lo), to_count(hi), $urandom_range(0, 3) == 0);
		foreach (pool[i])
			pool[i] = 8'($urandom);
		rel_pct = $urandom_range(15, 45);
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < rel_pct)
				op = ots_pkg::OP_RELEASE;
			else if (r < rel_pct + 35)
				op = ots_pkg::OP_ACQUIRE;
			else if (r < rel_pct + 50)
				op = ots_pkg::OP_TRY;
			else
				op = ots_pkg::OP_READ;
			if ($urandom_range(0, 9) < 8)
				owner = pool[$urandom_range(0, 5)];
			else
				owner = 8'($urandom_range(0, 255));
			send_request(op, owner);
		end
		settle();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_write_en    = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.op       = ots_pkg::OP_READ;
		req_ch.owner    = '0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Count 3, floor 0, ceiling 3: acquire down to the floor, queue two
		// waiters, then release everyone so both waiters are granted in turn.
		configure(16'd3, 16'd0, 16'd3, 1'b1);
		send_request(ots_pkg::OP_READ, 8'h00);
		send_request(ots_pkg::OP_TRY, 8'hFF);
		send_request(ots_pkg::OP_ACQUIRE, 8'h00);
		send_request(ots_pkg::OP_ACQUIRE, 8'hA5);
		send_request(ots_pkg::OP_TRY, 8'h5A);
		send_request(ots_pkg::OP_ACQUIRE, 8'h5A);
		send_request(ots_pkg::OP_ACQUIRE, 8'h33);
		send_request(ots_pkg::OP_RELEASE, 8'h77);
		send_request(ots_pkg::OP_RELEASE, 8'hFF);
		send_request(ots_pkg::OP_RELEASE, 8'h00);
		send_request(ots_pkg::OP_RELEASE, 8'h5A);
		send_request(ots_pkg::OP_RELEASE, 8'h33);
		send_request(ots_pkg::OP_RELEASE, 8'hA5);
		send_request(ots_pkg::OP_RELEASE, 8'hA5);
		settle();

		// Count at the ceiling with the widest window.
		configure(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
		send_request(ots_pkg::OP_ACQUIRE, 8'h80);
		send_request(ots_pkg::OP_RELEASE, 8'h80);
		send_request(ots_pkg::OP_READ, 8'hFF);
		settle();

		// Count stuck at the floor: a blocking acquire queues, a try is refused.
		configure(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
		send_request(ots_pkg::OP_ACQUIRE, 8'h01);
		send_request(ots_pkg::OP_TRY, 8'h02);
		settle();

		// Start above the ceiling: the release clamps down to it and grants
		// the waiter left queued by the previous setting.
		configure(16'd10, 16'd0, 16'd3, 1'b0);
		send_request(ots_pkg::OP_ACQUIRE, 8'h02);
		send_request(ots_pkg::OP_RELEASE, 8'h02);
		send_request(ots_pkg::OP_READ, 8'h00);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1) begin
				sender_gaps     = 1'b0;
				receiver_stalls = 1'b0;
			end else begin
				sender_gaps     = $urandom_range(0, 3) != 0;
				receiver_stalls = $urandom_range(0, 3) != 0;
			end
			random_phase(PHASE_ITEMS);
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("owner_tracked_counting_semaphore_tb OK");
		else
			$display("owner_tracked_counting_semaphore_tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/ots_pkg.sv
rtl/ots_req_if.sv
rtl/ots_rsp_if.sv
rtl/owner_tracked_counting_semaphore.sv
tb/owner_tracked_counting_semaphore_tb.sv
